FILE: hw/rtl/robust_holt_winters_smoother_assert.svh
// Assertion macros for the robust Holt-Winters smoother.
`ifndef ROBUST_HOLT_WINTERS_SMOOTHER_ASSERT_SVH
`define ROBUST_HOLT_WINTERS_SMOOTHER_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled during rst.
`define RHWS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rhws: same-cycle check failed");

// Next-cycle implication, sampled on clk and disabled during rst.
`define RHWS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rhws: next-cycle check failed");

`endif

FILE: hw/rtl/rhws_pkg.sv
// Shared types, constants and fixed-point helpers of the robust Holt-Winters smoother.
package rhws_pkg;

  localparam int MAX_PERIOD_DEF = 64;
  localparam int DIV_STEPS = 48;
  localparam int SQRT_STEPS = 32;
  localparam logic [16:0] ONE_Q = 17'd65536;

  typedef enum logic [2:0] {
    OP_SAMPLE = 3'd0,
    OP_LEVEL  = 3'd1,
    OP_TREND  = 3'd2,
    OP_SEASON = 3'd3,
    OP_SCALE  = 3'd4
  } opcode_t;

  typedef enum logic [2:0] {
    CFG_LEVEL_GAIN    = 3'd0,
    CFG_TREND_GAIN    = 3'd1,
    CFG_SEASON_GAIN   = 3'd2,
    CFG_SCALE_MEMORY  = 3'd3,
    CFG_CLIP_LIMIT    = 3'd4,
    CFG_WEIGHT_GAIN   = 3'd5,
    CFG_MODE_BITS     = 3'd6,
    CFG_SEASON_LENGTH = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic              start;
    logic signed [31:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] quo;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [63:0] x;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] root;
  } sqrt_rsp_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return v[31:0];
    end
  endfunction

  // Divide by 65536, rounding toward zero.
  function automatic logic signed [47:0] qtrunc(input logic signed [63:0] p);
    logic signed [63:0] b;
    b = p + (p[63] ? 64'sd65535 : 64'sd0);
    return b[63:16];
  endfunction

  function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
    return sat32(64'(qtrunc(p)));
  endfunction

  function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
    return {v[31], v};
  endfunction

  function automatic logic [16:0] gain_sat(input logic [16:0] v);
    return (v > ONE_Q) ? ONE_Q : v;
  endfunction

endpackage

FILE: hw/rtl/rhws_if.sv
// Handshake interfaces for the sample and result channels.
interface rhws_data_if;
  logic               valid;
  logic               ready;
  logic [2:0]         opcode;
  logic signed [31:0] value;
  logic [5:0]         slot;

  modport source (output valid, opcode, value, slot, input ready);
  modport sink (input valid, opcode, value, slot, output ready);
endinterface

interface rhws_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] forecast;
  logic signed [31:0] residual;
  logic signed [31:0] adjusted;
  logic signed [31:0] new_level;
  logic signed [31:0] new_trend;
  logic signed [31:0] new_season;
  logic [30:0]        new_scale;
  logic [62:0]        error_sum;

  modport source (output valid, forecast, residual, adjusted, new_level, new_trend,
                  new_season, new_scale, error_sum, input ready);
  modport sink (input valid, forecast, residual, adjusted, new_level, new_trend,
                new_season, new_scale, error_sum, output ready);
endinterface

FILE: hw/rtl/rhws_div.sv
// Shared restoring divider computing a saturated Q16.16 quotient, one bit a cycle.
module rhws_div
  import rhws_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int CW = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} dv_state_t;

  dv_state_t            state;
  logic [CW-1:0]        cnt;
  logic [31:0]          rem;
  logic [31:0]          dmag;
  logic [DIV_STEPS-1:0] qsh;
  logic                 neg;
  logic [31:0]          nraw;
  logic [31:0]          draw;
  logic [31:0]          num_mag;
  logic [31:0]          den_mag;
  logic [32:0]          trial;

  assign nraw    = req.num;
  assign draw    = req.den;
  assign num_mag = nraw[31] ? (~nraw + 32'd1) : nraw;
  assign den_mag = draw[31] ? (~draw + 32'd1) : draw;
  assign trial   = {rem, qsh[DIV_STEPS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= DV_IDLE;
      rsp.done <= 1'b0;
    end else begin
      rsp.done <= 1'b0;
      case (state)
        DV_IDLE: begin
          if (req.start) begin
            if (req.den == 32'sd0) begin
              rsp.quo  <= (req.num > 32'sd0) ? 32'sh7FFFFFFF :
                          ((req.num < 32'sd0) ? 32'sh80000000 : 32'sd0);
              rsp.done <= 1'b1;
            end else begin
              rem   <= '0;
              qsh   <= {num_mag, {(DIV_STEPS-32){1'b0}}};
              dmag  <= den_mag;
              neg   <= req.num[31] ^ req.den[31];
              cnt   <= '0;
              state <= DV_RUN;
            end
          end
        end
        DV_RUN: begin
          if (trial >= {1'b0, dmag}) begin
            rem <= 32'(trial - {1'b0, dmag});
            qsh <= {qsh[DIV_STEPS-2:0], 1'b1};
          end else begin
            rem <= trial[31:0];
            qsh <= {qsh[DIV_STEPS-2:0], 1'b0};
          end
          cnt <= cnt + CW'(1);
          if (cnt == CW'(DIV_STEPS - 1)) begin
            state <= DV_FIN;
          end
        end
        DV_FIN: begin
          if (!neg) begin
            rsp.quo <= (qsh > DIV_STEPS'(32'h7FFFFFFF)) ? 32'sh7FFFFFFF : qsh[31:0];
          end else begin
            rsp.quo <= (qsh > DIV_STEPS'(32'h80000000)) ? 32'sh80000000 :
                       (~qsh[31:0] + 32'd1);
          end
          rsp.done <= 1'b1;
          state    <= DV_IDLE;
        end
        default: state <= DV_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/rhws_sqrt.sv
// Bitwise floor square root of a 64-bit value, one result bit a cycle.
module rhws_sqrt
  import rhws_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  localparam int CW = $clog2(SQRT_STEPS);

  typedef enum logic {SQ_IDLE, SQ_RUN} sq_state_t;

  sq_state_t     state;
  logic [CW-1:0] cnt;
  logic [63:0]   rem;
  logic [63:0]   root;
  logic [63:0]   bitv;
  logic [63:0]   trial;
  logic          done;

  assign trial = root + bitv;
  assign rsp   = '{done: done, root: root[31:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        SQ_IDLE: begin
          if (req.start) begin
            rem   <= req.x;
            root  <= '0;
            bitv  <= 64'd1 << 62;
            cnt   <= '0;
            state <= SQ_RUN;
          end
        end
        SQ_RUN: begin
          if (rem >= trial) begin
            rem  <= rem - trial;
            root <= (root >> 1) + bitv;
          end else begin
            root <= root >> 1;
          end
          bitv <= bitv >> 2;
          cnt  <= cnt + CW'(1);
          if (cnt == CW'(SQRT_STEPS - 1)) begin
            done  <= 1'b1;
            state <= SQ_IDLE;
          end
        end
        default: state <= SQ_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/robust_holt_winters_smoother.sv
// Top level of the robust Holt-Winters smoother: sequencer, season memory and state.
//
// Usage: items arrive on the data channel (opcode, value, slot) with a valid/ready
// handshake; a beat is taken when both are high. Load opcodes (level, trend, season
// entry, scale) complete in the cycle they are accepted and give no result. A sample
// gives one beat on the result channel with forecast, residual, adjusted sample, the
// updated level, trend, season entry and scale, and the running squared-error sum.
// The time from acceptance to the result beat is set by the shared 48-step divider,
// used two to five times a sample depending on clipping and the multiplicative season
// mode (a zero divisor is answered without stepping), and by the 32-step square root;
// the remaining multiply steps share one 33x33 multiplier. The season ring sits in a
// synchronous memory read once per sample and written once per sample in season mode.
// Data ready is high only while no sample is in work; a finished result waits in the
// output register, and the next sample is accepted while it is still unread, but that
// sample's result holds in its last step until the receiver takes the previous beat.
// Reset clears level, trend, position and error sum, sets the scale to one and loads
// the configuration defaults; season entries are undefined until loaded.
// Configuration is written through cfg_write, cfg_index and cfg_data; the user must
// write it only while idle, which the block itself does not enforce.
`include "robust_holt_winters_smoother_assert.svh"

module robust_holt_winters_smoother
  import rhws_pkg::*;
#(
  parameter int MAX_PERIOD = MAX_PERIOD_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  rhws_data_if.sink   data,
  rhws_result_if.source result
);

  localparam int AW = (MAX_PERIOD > 1) ? $clog2(MAX_PERIOD) : 1;

  typedef enum logic [5:0] {
    S_IDLE, S_READ, S_SEAS, S_FCST, S_FCMUL, S_RES, S_UDIV, S_DIV, S_UCHK,
    S_RSQ, S_TSQ, S_TMUL, S_TCUBE, S_T3M, S_T3, S_RHOM, S_RHO, S_FM, S_FADD,
    S_SQRT, S_THM, S_TH, S_THDIV, S_PHIM, S_ADJ, S_SSEM, S_SSE, S_LVD,
    S_BL1, S_BL2, S_BL3, S_TRD, S_SND, S_FIN
  } state_t;

  typedef enum logic [2:0] {D_U, D_R, D_U2, D_LV, D_SN} div_use_t;
  typedef enum logic [1:0] {B_LV, B_TR, B_SN} blend_use_t;

  // Configuration registers.
  logic [16:0] level_gain;
  logic [16:0] trend_gain;
  logic [16:0] season_gain;
  logic [16:0] scale_memory;
  logic [30:0] clip_limit;
  logic [30:0] weight_gain;
  logic [2:0]  mode_bits;
  logic [6:0]  season_length;

  always_ff @(posedge clk) begin
    if (rst) begin
      level_gain    <= '0;
      trend_gain    <= '0;
      season_gain   <= '0;
      scale_memory  <= '0;
      clip_limit    <= 31'(ONE_Q);
      weight_gain   <= 31'(ONE_Q);
      mode_bits     <= 3'd1;
      season_length <= 7'd12;
    end else if (cfg_write) begin
      case (cfg_idx_t'(cfg_index))
        CFG_LEVEL_GAIN:    level_gain    <= gain_sat(cfg_data[16:0]);
        CFG_TREND_GAIN:    trend_gain    <= gain_sat(cfg_data[16:0]);
        CFG_SEASON_GAIN:   season_gain   <= gain_sat(cfg_data[16:0]);
        CFG_SCALE_MEMORY:  scale_memory  <= gain_sat(cfg_data[16:0]);
        CFG_CLIP_LIMIT:    clip_limit    <= cfg_data;
        CFG_WEIGHT_GAIN:   weight_gain   <= cfg_data;
        CFG_MODE_BITS:     mode_bits     <= cfg_data[2:0];
        CFG_SEASON_LENGTH: season_length <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  logic additive;
  logic trend_on;
  logic season_on;
  logic [32:0] k33;

  assign additive  = mode_bits[0];
  assign trend_on  = mode_bits[1];
  assign season_on = mode_bits[2];
  assign k33       = {2'b00, (clip_limit == '0) ? 31'd1 : clip_limit};

  // Sequencer state and datapath registers.
  state_t             state;
  div_use_t           dsel;
  blend_use_t         bsel;
  logic signed [31:0] level;
  logic signed [31:0] trend;
  logic [30:0]        scale;
  logic [AW-1:0]      pos;
  logic [62:0]        sse;
  logic signed [31:0] x;
  logic signed [31:0] lt;
  logic signed [31:0] stmp;
  logic signed [31:0] xhat;
  logic signed [31:0] res;
  logic signed [31:0] u;
  logic signed [32:0] tmp;
  logic signed [32:0] tmp2;
  logic signed [31:0] rho;
  logic [30:0]        theta;
  logic signed [32:0] phi;
  logic signed [31:0] adj;
  logic signed [31:0] dval;
  logic signed [31:0] nl;
  logic signed [31:0] nt;
  logic signed [31:0] ns;
  logic signed [63:0] prod;
  logic signed [63:0] acc;

  // Season period and position.
  logic [31:0]   len32;
  logic [31:0]   per32;
  logic [AW:0]   period;
  logic [AW:0]   pos_ext;
  logic [AW:0]   pos_inc;
  logic [AW-1:0] pos_eff;
  logic [AW-1:0] pos_next;

  always_comb begin
    len32 = 32'(season_length);
    if (len32 == 32'd0) begin
      per32 = 32'd1;
    end else if (len32 > 32'(MAX_PERIOD)) begin
      per32 = 32'(MAX_PERIOD);
    end else begin
      per32 = len32;
    end
    period   = per32[AW:0];
    pos_ext  = {1'b0, pos};
    pos_eff  = (pos_ext < period) ? pos : '0;
    pos_inc  = pos_ext + (AW+1)'(1);
    pos_next = (pos_inc >= period) ? '0 : pos_inc[AW-1:0];
  end

  // Season memory.
  logic signed [31:0] season_mem [MAX_PERIOD];
  logic signed [31:0] ram_q;
  logic               wr_en;
  logic [AW-1:0]      wr_addr;
  logic signed [31:0] wr_data;
  logic               commit;
  logic               load_season;

  assign commit      = (state == S_FIN) && (!result.valid || result.ready);
  assign load_season = (state == S_IDLE) && data.valid &&
                       (opcode_t'(data.opcode) == OP_SEASON) &&
                       (32'(data.slot) < 32'(MAX_PERIOD));

  always_comb begin
    if (load_season) begin
      wr_en   = 1'b1;
      wr_addr = AW'(data.slot);
      wr_data = data.value;
    end else begin
      wr_en   = commit && season_on;
      wr_addr = pos;
      wr_data = ns;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      season_mem[wr_addr] <= wr_data;
    end
    if (state == S_READ) begin
      ram_q <= season_mem[pos_eff];
    end
  end

  // Divider and square root interfaces.
  div_req_t  div_req;
  div_rsp_t  div_rsp;
  sqrt_req_t sqrt_req;
  sqrt_rsp_t sqrt_rsp;

  // Shared multiplier.
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_full;
  logic [16:0]        g_sel;
  logic signed [31:0] q_sel;

  always_comb begin
    case (bsel)
      B_LV: begin
        g_sel = level_gain;
        q_sel = lt;
      end
      B_TR: begin
        g_sel = trend_gain;
        q_sel = trend;
      end
      B_SN: begin
        g_sel = season_gain;
        q_sel = stmp;
      end
      default: begin
        g_sel = level_gain;
        q_sel = lt;
      end
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_FCST: begin
        mul_a = sx33(lt);
        mul_b = sx33(stmp);
      end
      S_RSQ, S_TMUL: begin
        mul_a = tmp;
        mul_b = tmp;
      end
      S_T3M: begin
        mul_a = tmp2;
        mul_b = tmp;
      end
      S_RHOM: begin
        mul_a = $signed({2'b00, weight_gain});
        mul_b = tmp;
      end
      S_FM: begin
        mul_a = $signed({16'd0, scale_memory});
        mul_b = sx33(rho);
      end
      S_THM: begin
        mul_a = $signed({2'b00, scale});
        mul_b = $signed({1'b0, sqrt_rsp.root});
      end
      S_PHIM: begin
        mul_a = phi;
        mul_b = $signed({2'b00, theta});
      end
      S_SSEM: begin
        mul_a = sx33(res);
        mul_b = sx33(res);
      end
      S_BL1: begin
        mul_a = $signed({16'd0, g_sel});
        mul_b = sx33(dval);
      end
      S_BL2: begin
        mul_a = $signed({16'd0, ONE_Q - g_sel});
        mul_b = sx33(q_sel);
      end
      default: ;
    endcase
  end

  assign mul_full = mul_a * mul_b;

  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
  end

  // Divider and square root units.
  logic [32:0] u_abs;
  logic [32:0] q_abs;
  logic [32:0] u_ext;
  logic [32:0] q_ext;
  logic [32:0] f33;

  assign u_ext = {u[31], u};
  assign q_ext = {div_rsp.quo[31], div_rsp.quo};
  assign u_abs = u[31] ? (~u_ext + 33'd1) : u_ext;
  assign q_abs = div_rsp.quo[31] ? (~q_ext + 33'd1) : q_ext;
  assign f33   = prod[48:16] + {16'd0, ONE_Q - scale_memory};

  always_comb begin
    div_req.start = 1'b0;
    div_req.num   = res;
    div_req.den   = $signed({1'b0, scale});
    case (state)
      S_UDIV: div_req.start = 1'b1;
      S_UCHK: begin
        div_req.start = (u_abs <= k33);
        div_req.num   = u;
        div_req.den   = $signed(k33[31:0]);
      end
      S_THDIV: begin
        div_req.start = 1'b1;
        div_req.den   = $signed({1'b0, theta});
      end
      S_LVD: begin
        div_req.start = !additive;
        div_req.num   = adj;
        div_req.den   = stmp;
      end
      S_SND: begin
        div_req.start = season_on && !additive;
        div_req.num   = adj;
        div_req.den   = nl;
      end
      default: ;
    endcase
  end

  assign sqrt_req.start = (state == S_FADD);
  assign sqrt_req.x     = {15'd0, f33, 16'd0};

  rhws_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  rhws_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sqrt_req),
    .rsp (sqrt_rsp)
  );

  assign data.ready = (state == S_IDLE);

  logic signed [31:0] trend_eff;
  logic [47:0]        th_full;
  logic [63:0]        sse_sum;

  assign trend_eff = trend_on ? trend : 32'sd0;
  assign th_full   = prod[63:16];
  assign sse_sum   = {1'b0, sse} + {1'b0, prod[62:0]};

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      level        <= '0;
      trend        <= '0;
      scale        <= 31'(ONE_Q);
      pos          <= '0;
      sse          <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (data.valid) begin
            case (opcode_t'(data.opcode))
              OP_SAMPLE: begin
                x     <= data.value;
                state <= S_READ;
              end
              OP_LEVEL: level <= data.value;
              OP_TREND: trend <= data.value;
              OP_SCALE: scale <= data.value[31] ? '0 : data.value[30:0];
              default: ;
            endcase
          end
        end
        S_READ: begin
          lt    <= sat32(64'(level) + 64'(trend_eff));
          pos   <= pos_eff;
          state <= S_SEAS;
        end
        S_SEAS: begin
          stmp  <= season_on ? ram_q : (additive ? 32'sd0 : 32'(ONE_Q));
          state <= S_FCST;
        end
        S_FCST: begin
          if (additive) begin
            xhat  <= sat32(64'(lt) + 64'(stmp));
            state <= S_RES;
          end else begin
            state <= S_FCMUL;
          end
        end
        S_FCMUL: begin
          xhat  <= mulq(prod);
          state <= S_RES;
        end
        S_RES: begin
          res   <= sat32(64'(x) - 64'(xhat));
          state <= S_UDIV;
        end
        S_UDIV: begin
          dsel  <= D_U;
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            case (dsel)
              D_U: begin
                u     <= div_rsp.quo;
                state <= S_UCHK;
              end
              D_R: begin
                tmp   <= sx33(div_rsp.quo);
                state <= S_RSQ;
              end
              D_U2: begin
                if (q_abs < k33) begin
                  phi <= sx33(div_rsp.quo);
                end else begin
                  phi <= div_rsp.quo[31] ? $signed(~k33 + 33'd1) : $signed(k33);
                end
                state <= S_PHIM;
              end
              D_LV: begin
                dval  <= div_rsp.quo;
                bsel  <= B_LV;
                state <= S_BL1;
              end
              D_SN: begin
                dval  <= div_rsp.quo;
                bsel  <= B_SN;
                state <= S_BL1;
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_UCHK: begin
          if (u_abs <= k33) begin
            dsel  <= D_R;
            state <= S_DIV;
          end else begin
            rho   <= $signed({1'b0, weight_gain});
            state <= S_FM;
          end
        end
        S_RSQ:   state <= S_TSQ;
        S_TSQ: begin
          tmp   <= 33'sd65536 - sx33(mulq(prod));
          state <= S_TMUL;
        end
        S_TMUL:  state <= S_TCUBE;
        S_TCUBE: begin
          tmp2  <= sx33(mulq(prod));
          state <= S_T3M;
        end
        S_T3M:   state <= S_T3;
        S_T3: begin
          tmp   <= 33'sd65536 - sx33(mulq(prod));
          state <= S_RHOM;
        end
        S_RHOM:  state <= S_RHO;
        S_RHO: begin
          rho   <= mulq(prod);
          state <= S_FM;
        end
        S_FM:    state <= S_FADD;
        S_FADD:  state <= S_SQRT;
        S_SQRT: begin
          if (sqrt_rsp.done) begin
            state <= S_THM;
          end
        end
        S_THM:   state <= S_TH;
        S_TH: begin
          theta <= (th_full > 48'h7FFFFFFF) ? 31'h7FFFFFFF : th_full[30:0];
          state <= S_THDIV;
        end
        S_THDIV: begin
          dsel  <= D_U2;
          state <= S_DIV;
        end
        S_PHIM:  state <= S_ADJ;
        S_ADJ: begin
          adj   <= sat32(64'(qtrunc(prod)) + 64'(xhat));
          state <= S_SSEM;
        end
        S_SSEM:  state <= S_SSE;
        S_SSE: begin
          sse   <= sse_sum[63] ? '1 : sse_sum[62:0];
          state <= S_LVD;
        end
        S_LVD: begin
          if (additive) begin
            dval  <= sat32(64'(adj) - 64'(stmp));
            bsel  <= B_LV;
            state <= S_BL1;
          end else begin
            dsel  <= D_LV;
            state <= S_DIV;
          end
        end
        S_BL1:   state <= S_BL2;
        S_BL2: begin
          acc   <= prod;
          state <= S_BL3;
        end
        S_BL3: begin
          case (bsel)
            B_LV: begin
              nl    <= mulq(acc + prod);
              state <= S_TRD;
            end
            B_TR: begin
              nt    <= mulq(acc + prod);
              state <= S_SND;
            end
            B_SN: begin
              ns    <= mulq(acc + prod);
              state <= S_FIN;
            end
            default: state <= S_IDLE;
          endcase
        end
        S_TRD: begin
          if (trend_on) begin
            dval  <= sat32(64'(nl) - 64'(level));
            bsel  <= B_TR;
            state <= S_BL1;
          end else begin
            nt    <= '0;
            state <= S_SND;
          end
        end
        S_SND: begin
          if (!season_on) begin
            ns    <= '0;
            state <= S_FIN;
          end else if (additive) begin
            dval  <= sat32(64'(adj) - 64'(nl));
            bsel  <= B_SN;
            state <= S_BL1;
          end else begin
            dsel  <= D_SN;
            state <= S_DIV;
          end
        end
        S_FIN: begin
          if (commit) begin
            result.valid      <= 1'b1;
            result.forecast   <= xhat;
            result.residual   <= res;
            result.adjusted   <= adj;
            result.new_level  <= nl;
            result.new_trend  <= nt;
            result.new_season <= ns;
            result.new_scale  <= theta;
            result.error_sum  <= sse;
            level             <= nl;
            if (trend_on) begin
              trend <= nt;
            end
            scale <= theta;
            pos   <= pos_next;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic fin_stall;

  assign fin_stall = (state == S_FIN) && result.valid && !result.ready;

  `RHWS_ASSERT_IMPLIES(a_div_done_in_wait, div_rsp.done, state == S_DIV)
  `RHWS_ASSERT_IMPLIES(a_sqrt_done_in_wait, sqrt_rsp.done, state == S_SQRT)
  `RHWS_ASSERT_IMPLIES(a_pos_in_period, state == S_FIN, pos_ext < period)
  `RHWS_ASSERT_NEXT(a_fin_holds_on_stall, fin_stall, state == S_FIN)

endmodule

FILE: tb/rhws_checker.sv
// Checker for the robust Holt-Winters smoother: predicts each sample's result and compares it.
`timescale 1ns / 100ps

module rhws_checker
  import rhws_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [30:0] cfg_data,
  rhws_data_if        data,
  rhws_result_if      result,
  output int          fail_count,
  output int          pending,
  output int          beats_checked
);

  localparam longint UNIT = 65536;
  localparam longint POS_LIMIT = 64'sd2147483647;
  localparam longint NEG_LIMIT = -64'sd2147483648;
  localparam longint unsigned SSE_CEIL = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [31:0] forecast;
    logic signed [31:0] residual;
    logic signed [31:0] adjusted;
    logic signed [31:0] new_level;
    logic signed [31:0] new_trend;
    logic signed [31:0] new_season;
    logic [30:0]        new_scale;
    logic [62:0]        error_sum;
  } smoothed_t;

  smoothed_t smoothed_q[$];

  longint alpha, beta, gamma, lambda, clip_k, rho_gain, mode, period_cfg;
  longint level_est, trend_est, theta_est;
  longint ring[MAX_PERIOD_DEF];
  int ring_pos;
  longint unsigned sq_err_sum;

  function automatic longint clamp32(input longint v);
    return v > POS_LIMIT ? POS_LIMIT : (v < NEG_LIMIT ? NEG_LIMIT : v);
  endfunction

  function automatic longint qmul(input longint a, input longint b);
    return clamp32((a * b) / UNIT);
  endfunction

  function automatic longint qdiv(input longint a, input longint b);
    if (b == 0) begin
      return a > 0 ? POS_LIMIT : (a < 0 ? NEG_LIMIT : 0);
    end
    return clamp32((a * UNIT) / b);
  endfunction

  function automatic longint mix(input longint g, input longint p, input longint q);
    return clamp32((g * p + (UNIT - g) * q) / UNIT);
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint gain_of(input logic [30:0] d);
    return d[16:0] > 17'd65536 ? UNIT : longint'(d[16:0]);
  endfunction

  task automatic predict_sample(input longint x);
    longint period, k, lt, stmp, xhat, res, u, rho, f, theta, u2, phi, adj;
    longint r, t, t3, old_level, nl, nt, ns, d;
    longint unsigned sq;
    int slot_now;
    bit additive, trend_on, season_on;
    smoothed_t o;
    additive = mode[0];
    trend_on = mode[1];
    season_on = mode[2];
    nt = 0;
    ns = 0;
    period = period_cfg == 0 ? 1 : (period_cfg > MAX_PERIOD_DEF ? MAX_PERIOD_DEF : period_cfg);
    slot_now = ring_pos < period ? ring_pos : 0;
    k = clip_k == 0 ? 1 : clip_k;

    lt = clamp32(level_est + (trend_on ? trend_est : 0));
    stmp = season_on ? ring[slot_now] : (additive ? 0 : UNIT);
    xhat = additive ? clamp32(lt + stmp) : qmul(lt, stmp);
    res = clamp32(x - xhat);

    u = qdiv(res, theta_est);
    if ((u < 0 ? -u : u) <= k) begin
      r = qdiv(u, k);
      t = UNIT - qmul(r, r);
      t3 = qmul(qmul(t, t), t);
      rho = qmul(rho_gain, UNIT - t3);
    end else begin
      rho = rho_gain;
    end
    f = (lambda * rho) / UNIT + (UNIT - lambda);
    theta = (theta_est * longint'(floor_root(longint'(f) * UNIT))) / UNIT;
    if (theta > POS_LIMIT) theta = POS_LIMIT;
    theta_est = theta;

    u2 = qdiv(res, theta);
    if ((u2 < 0 ? -u2 : u2) < k) phi = u2;
    else phi = u2 > 0 ? k : -k;
    adj = clamp32((phi * theta) / UNIT + xhat);

    sq = longint'(res * res);
    sq_err_sum = (SSE_CEIL - sq_err_sum < sq) ? SSE_CEIL : sq_err_sum + sq;

    old_level = level_est;
    d = additive ? clamp32(adj - stmp) : qdiv(adj, stmp);
    nl = mix(alpha, d, lt);
    level_est = nl;
    if (trend_on) begin
      nt = mix(beta, clamp32(nl - old_level), trend_est);
      trend_est = nt;
    end
    if (season_on) begin
      d = additive ? clamp32(adj - nl) : qdiv(adj, nl);
      ns = mix(gamma, d, stmp);
      ring[slot_now] = ns;
    end
    ring_pos = (slot_now + 1 >= period) ? 0 : slot_now + 1;

    o.forecast = xhat[31:0];
    o.residual = res[31:0];
    o.adjusted = adj[31:0];
    o.new_level = nl[31:0];
    o.new_trend = nt[31:0];
    o.new_season = ns[31:0];
    o.new_scale = theta[30:0];
    o.error_sum = sq_err_sum[62:0];
    smoothed_q.push_back(o);
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on %s at %0t: got %h, expected %h", field, $realtime, got, want);
    fail_count++;
  endtask

  task automatic check_beat();
    smoothed_t e;
    if (smoothed_q.size() == 0) begin
      $display("unexpected result beat at %0t", $realtime);
      fail_count++;
      return;
    end
    e = smoothed_q.pop_front();
    beats_checked++;
    if (result.forecast !== e.forecast) report_mismatch("forecast", result.forecast, e.forecast);
    if (result.residual !== e.residual) report_mismatch("residual", result.residual, e.residual);
    if (result.adjusted !== e.adjusted) report_mismatch("adjusted", result.adjusted, e.adjusted);
    if (result.new_level !== e.new_level)
      report_mismatch("new_level", result.new_level, e.new_level);
    if (result.new_trend !== e.new_trend)
      report_mismatch("new_trend", result.new_trend, e.new_trend);
    if (result.new_season !== e.new_season)
      report_mismatch("new_season", result.new_season, e.new_season);
    if (result.new_scale !== e.new_scale)
      report_mismatch("new_scale", result.new_scale, e.new_scale);
    if (result.error_sum !== e.error_sum)
      report_mismatch("error_sum", result.error_sum, e.error_sum);
  endtask

  initial begin
    fail_count = 0;
    beats_checked = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    longint x;
    if (rst) begin
      alpha = 0;
      beta = 0;
      gamma = 0;
      lambda = 0;
      clip_k = UNIT;
      rho_gain = UNIT;
      mode = 1;
      period_cfg = 12;
      level_est = 0;
      trend_est = 0;
      theta_est = UNIT;
      foreach (ring[i]) ring[i] = 0;
      ring_pos = 0;
      sq_err_sum = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_idx_t'(cfg_index))
          CFG_LEVEL_GAIN:    alpha = gain_of(cfg_data);
          CFG_TREND_GAIN:    beta = gain_of(cfg_data);
          CFG_SEASON_GAIN:   gamma = gain_of(cfg_data);
          CFG_SCALE_MEMORY:  lambda = gain_of(cfg_data);
          CFG_CLIP_LIMIT:    clip_k = longint'(cfg_data);
          CFG_WEIGHT_GAIN:   rho_gain = longint'(cfg_data);
          CFG_MODE_BITS:     mode = longint'(cfg_data[2:0]);
          CFG_SEASON_LENGTH: period_cfg = longint'(cfg_data[6:0]);
          default: ;
        endcase
      end
      if (result.valid && result.ready) check_beat();
      if (data.valid && data.ready) begin
        x = longint'(data.value);
        case (data.opcode)
          OP_SAMPLE: predict_sample(x);
          OP_LEVEL:  level_est = x;
          OP_TREND:  trend_est = x;
          OP_SEASON: ring[data.slot] = x;
          OP_SCALE:  theta_est = x < 0 ? 0 : x;
          default: ;
        endcase
      end
    end
    pending <= smoothed_q.size();
  end

endmodule

FILE: tb/tb.sv
// Testbench top for the robust Holt-Winters smoother: stimulus, configuration and verdict.
`timescale 1ns / 100ps

module tb;
  import rhws_pkg::*;

  localparam logic [2:0] OP_RESERVED_LO = 3'd5;
  localparam logic [2:0] OP_RESERVED_HI = 3'd7;
  localparam int PHASES = 8;
  localparam int ITEMS_PER_PHASE = 140;
  localparam int LONG_HOLD = 2500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [2:0] cfg_index = CFG_LEVEL_GAIN;
  logic [30:0] cfg_data = '0;
  bit send_gaps = 1'b1;
  bit take_gaps = 1'b1;
  bit hold_request = 1'b0;
  int fail_count, pending, beats_checked;
  int samples_sent = 0;

  rhws_data_if data ();
  rhws_result_if result ();

  robust_holt_winters_smoother dut (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .data(data), .result(result)
  );

  rhws_checker checker_i (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .data(data), .result(result), .fail_count(fail_count),
    .pending(pending), .beats_checked(beats_checked)
  );

  always #5 clk = ~clk;

  initial begin
    data.valid = 1'b0;
    data.opcode = OP_SAMPLE;
    data.value = '0;
    data.slot = '0;
    result.ready = 1'b0;
  end

  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off when the stimulus asks for it.
  initial begin
    int n;
    @(negedge rst);
    forever begin
      @(posedge clk);
      if (hold_request) begin
        result.ready <= 1'b0;
        hold_request = 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        result.ready <= 1'b1;
      end else if (take_gaps && $urandom_range(3) == 0) begin
        n = $urandom_range(4, 1);
        result.ready <= 1'b0;
        repeat (n) @(posedge clk);
        result.ready <= 1'b1;
      end else begin
        result.ready <= 1'b1;
      end
    end
  end

  task automatic send_beat(input logic [2:0] op, input logic [31:0] v, input logic [5:0] s);
    if (send_gaps && $urandom_range(4) == 0) begin
      data.valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    data.valid <= 1'b1;
    data.opcode <= op;
    data.value <= v;
    data.slot <= s;
    do @(posedge clk); while (!data.ready);
    if (op == OP_SAMPLE) samples_sent++;
  endtask

  task automatic drain();
    data.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [30:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [30:0] pick_gain(input int ph);
    case ($urandom_range(4))
      0: return 31'd0;
      1: return 31'd65536;
      2: return 31'h1FFFF;
      default: return 31'($urandom_range(65536));
    endcase
  endfunction

  task automatic configure(input int ph);
    write_reg(CFG_LEVEL_GAIN, pick_gain(ph));
    write_reg(CFG_TREND_GAIN, pick_gain(ph));
    write_reg(CFG_SEASON_GAIN, pick_gain(ph));
    write_reg(CFG_SCALE_MEMORY, pick_gain(ph));
    case (ph % 4)
      0: write_reg(CFG_CLIP_LIMIT, 31'd0);
      1: write_reg(CFG_CLIP_LIMIT, 31'h7FFFFFFF);
      default: write_reg(CFG_CLIP_LIMIT, 31'($urandom_range(262144, 16384)));
    endcase
    case (ph % 3)
      0: write_reg(CFG_WEIGHT_GAIN, 31'h7FFFFFFF);
      1: write_reg(CFG_WEIGHT_GAIN, 31'd0);
      default: write_reg(CFG_WEIGHT_GAIN, 31'($urandom_range(196608, 32768)));
    endcase
    write_reg(CFG_MODE_BITS, 31'(ph % 8));
    case (ph % 4)
      0: write_reg(CFG_SEASON_LENGTH, 31'd0);
      1: write_reg(CFG_SEASON_LENGTH, 31'd127);
      2: write_reg(CFG_SEASON_LENGTH, 31'd64);
      default: write_reg(CFG_SEASON_LENGTH, 31'($urandom_range(12, 1)));
    endcase
  endtask

  function automatic logic [31:0] series_value();
    case ($urandom_range(19))
      0: return $urandom;
      1: return 32'(int'($urandom_range(400, 0)) - 200) << 16;
      default: return 32'((int'($urandom_range(20, 0)) << 16)
                          + int'($urandom_range(131072)) - 65536);
    endcase
  endfunction

  task automatic load_season_ring();
    for (int i = 0; i < MAX_PERIOD_DEF; i++)
      send_beat(OP_SEASON, 32'($urandom_range(98304, 32768)), 6'(i));
  endtask

  task automatic random_items(input int count);
    int done_items;
    int pick;
    done_items = 0;
    while (done_items < count) begin
      pick = $urandom_range(99);
      if (pick < 85) begin
        send_beat(OP_SAMPLE, series_value(), 6'($urandom));
        done_items++;
      end else if (pick < 89) send_beat(OP_SEASON, series_value(), 6'($urandom));
      else if (pick < 92) send_beat(OP_LEVEL, series_value(), 6'($urandom));
      else if (pick < 94) send_beat(OP_TREND, 32'($urandom_range(8192)) - 32'd4096, 6'($urandom));
      else if (pick < 97) send_beat(OP_SCALE, $urandom_range(1) ? $urandom : 32'($urandom_range(262144)),
                                    6'($urandom));
      else send_beat(3'($urandom_range(OP_RESERVED_HI, OP_RESERVED_LO)), $urandom, 6'($urandom));
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: defaults, extremes of the sample value and of the level, trend and scale loads.
    load_season_ring();
    send_beat(OP_SAMPLE, 32'h7FFFFFFF, 6'h3F);
    send_beat(OP_SAMPLE, 32'h80000000, 6'h00);
    send_beat(OP_SAMPLE, 32'h0, 6'h2A);
    send_beat(OP_SAMPLE, 32'hFFFFFFFF, 6'h15);
    send_beat(OP_LEVEL, 32'h7FFFFFFF, 6'h0);
    send_beat(OP_TREND, 32'h7FFFFFFF, 6'h0);
    send_beat(OP_SAMPLE, 32'h80000000, 6'h0);
    send_beat(OP_SCALE, 32'h80000000, 6'h0);
    send_beat(OP_SAMPLE, 32'h00050000, 6'h0);
    send_beat(OP_SAMPLE, 32'hFFFB0000, 6'h0);
    send_beat(OP_SCALE, 32'h7FFFFFFF, 6'h0);
    send_beat(OP_LEVEL, 32'h80000000, 6'h0);
    send_beat(OP_SAMPLE, 32'h7FFFFFFF, 6'h0);
    send_beat(OP_SEASON, 32'h0, 6'h3F);
    send_beat(OP_RESERVED_LO, 32'h12345678, 6'h3F);
    send_beat(OP_RESERVED_HI, 32'hEDCBA987, 6'h0);
    send_beat(OP_SCALE, 32'h00010000, 6'h0);
    send_beat(OP_LEVEL, 32'h00010000, 6'h0);
    send_beat(OP_TREND, 32'h0, 6'h0);
    send_beat(OP_SAMPLE, 32'h00020000, 6'h0);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      configure(ph);
      if (ph % 2 == 0) load_season_ring();
      send_beat(OP_LEVEL, 32'(int'($urandom_range(10, 0)) << 16), 6'h0);
      send_beat(OP_SCALE, 32'h00010000, 6'h0);
      if (ph == 2) hold_request = 1'b1;
      if (ph == PHASES - 1) begin
        send_gaps = 1'b0;
        take_gaps = 1'b0;
      end
      random_items(ITEMS_PER_PHASE);
      drain();
    end

    $display("Sent %0d samples over %0d register settings, all eight modes included;",
             samples_sent, PHASES + 1);
    $display("%0d result beats were checked field by field.", beats_checked);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
